// ===== sv/mcp_pkg.sv =====
// Shared types, constants and character tables for the motor command parser.
// Used by mcp_front, mcp_queue, mcp_back and motor_command_parser.
`default_nettype none

package mcp_pkg;

	// Line parser phases.
	typedef enum logic [2:0] {
		PH_LEAD,
		PH_BODY,
		PH_FIELD1,
		PH_FIELD2,
		PH_DEAD
	} phase_t;

	// Number reader phases.
	typedef enum logic [1:0] {
		NUM_SKIP,
		NUM_DIGIT,
		NUM_STOP
	} num_phase_t;

	// Classified commands, keyword codes first in table order.
	typedef enum logic [2:0] {
		CMD_FWD,
		CMD_BWD,
		CMD_LEFT,
		CMD_RIGHT,
		CMD_STOP,
		CMD_MOTOR
	} cmd_t;

	// Queue status seen by both sides of the queue.
	typedef struct packed {
		logic full;
		logic empty;
	} queue_status_t;

	// Configuration register indexes.
	localparam int unsigned CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_STRAIGHT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TURN     = 2'd1;

	localparam logic [7:0] STRAIGHT_RESET = 8'd200;
	localparam logic [7:0] TURN_RESET     = 8'd150;

	// Queue geometry.
	localparam int unsigned QUEUE_AW    = 2;
	localparam int unsigned QUEUE_DEPTH = 1 << QUEUE_AW;

	// Character codes.
	localparam logic [7:0] CH_NEWLINE = 8'd10;
	localparam logic [7:0] CH_SPACE   = 8'd32;
	localparam logic [7:0] CH_TAB     = 8'd9;
	localparam logic [7:0] CH_CR      = 8'd13;
	localparam logic [7:0] CH_COMMA   = ",";
	localparam logic [7:0] CH_PLUS    = "+";
	localparam logic [7:0] CH_MINUS   = "-";
	localparam logic [7:0] CH_ZERO    = "0";
	localparam logic [7:0] CH_NINE    = "9";

	// Keyword table: five keywords and the motor prefix.
	localparam int unsigned KW_COUNT   = 6;
	localparam int unsigned KW_PREFIX  = 5;
	localparam logic [KW_COUNT-1:0] KW_ALL = '1;

	localparam logic [7:0] KW_TEXT [KW_COUNT][5] = '{
		'{"F", "W", "D", 8'h00, 8'h00},
		'{"B", "W", "D", 8'h00, 8'h00},
		'{"L", "E", "F", "T", 8'h00},
		'{"R", "I", "G", "H", "T"},
		'{"S", "T", "O", "P", 8'h00},
		'{"M", ":", 8'h00, 8'h00, 8'h00}
	};
	localparam logic [2:0] KW_LEN [KW_COUNT] = '{3'd3, 3'd3, 3'd4, 3'd5, 3'd4, 3'd2};

	// Whitespace as the line trimmer and number reader see it.
	function automatic logic is_space(input logic [7:0] c);
		return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
	endfunction

endpackage

`default_nettype wire

// ===== sv/mcp_front.sv =====
// Front end: accepts received bytes, trims and classifies each line, and pushes
// one classified command per valid line into the queue. Depends on mcp_pkg.
`default_nettype none

module mcp_front #(
	parameter int unsigned DUTY_MAX = 255,
	parameter int unsigned MAG_W    = 8,
	parameter int unsigned ENTRY_W  = 5 + 2 * MAG_W
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   in_valid,
	input  wire logic [7:0]             rx_byte,
	input  wire logic                   q_full,
	output logic                        push,
	output logic [ENTRY_W-1:0]          push_entry
);

	localparam int unsigned PROD_W = MAG_W + 4;

	mcp_pkg::phase_t                   phase_q, phase_d;
	logic [mcp_pkg::KW_COUNT-1:0]      alive_q, alive_d;
	logic [2:0]                        pos_q, pos_d;
	logic                              trail_q, trail_d;
	mcp_pkg::num_phase_t               num_q, num_d;
	logic                              ffne_q, ffne_d;
	logic                              lneg_q, lneg_d;
	logic [MAG_W-1:0]                  lmag_q, lmag_d;
	logic                              rneg_q, rneg_d;
	logic [MAG_W-1:0]                  rmag_q, rmag_d;

	logic                              accept;
	logic                              c_space;
	logic                              c_digit;
	logic [mcp_pkg::KW_COUNT-1:0]      alive_body;
	logic [2:0]                        pos_inc;
	logic                              kw_found;
	mcp_pkg::cmd_t                     kw_cmd;
	mcp_pkg::cmd_t                     push_cmd;

	// Shared number reader for whichever field is active.
	logic                              fld_neg, fld_neg_n;
	logic [MAG_W-1:0]                  fld_mag, fld_mag_n;
	mcp_pkg::num_phase_t               num_n;
	logic [PROD_W-1:0]                 prod;

	assign accept  = in_valid && !q_full;
	assign c_space = mcp_pkg::is_space(rx_byte);
	assign c_digit = (rx_byte >= mcp_pkg::CH_ZERO) && (rx_byte <= mcp_pkg::CH_NINE);
	assign pos_inc = (pos_q == 3'd7) ? pos_q : pos_q + 3'd1;

	// Keyword candidates that survive this character.
	always_comb begin
		for (int k = 0; k < mcp_pkg::KW_COUNT; k++) begin
			alive_body[k] = alive_q[k] && (pos_q < mcp_pkg::KW_LEN[k]) &&
				(mcp_pkg::KW_TEXT[k][pos_q] == rx_byte);
		end
	end

	// First keyword that is alive and completely matched at line end.
	always_comb begin
		kw_found = 1'b0;
		kw_cmd   = mcp_pkg::CMD_STOP;
		for (int k = 0; k < mcp_pkg::KW_PREFIX; k++) begin
			if (!kw_found && alive_q[k] && pos_q == mcp_pkg::KW_LEN[k]) begin
				kw_found = 1'b1;
				kw_cmd   = mcp_pkg::cmd_t'(3'(k));
			end
		end
	end

	// One character step of the number reader.
	always_comb begin
		fld_neg = (phase_q == mcp_pkg::PH_FIELD2) ? rneg_q : lneg_q;
		fld_mag = (phase_q == mcp_pkg::PH_FIELD2) ? rmag_q : lmag_q;
		prod    = (PROD_W'(fld_mag) << 3) + (PROD_W'(fld_mag) << 1) +
			PROD_W'(rx_byte[3:0]);
		fld_neg_n = fld_neg;
		fld_mag_n = fld_mag;
		num_n     = num_q;
		if (num_q != mcp_pkg::NUM_STOP) begin
			if (c_digit) begin
				fld_mag_n = (prod > PROD_W'(DUTY_MAX)) ? MAG_W'(DUTY_MAX) : prod[MAG_W-1:0];
				num_n     = mcp_pkg::NUM_DIGIT;
			end else if (num_q == mcp_pkg::NUM_SKIP &&
				(rx_byte == mcp_pkg::CH_PLUS || rx_byte == mcp_pkg::CH_MINUS)) begin
				fld_neg_n = (rx_byte == mcp_pkg::CH_MINUS);
				num_n     = mcp_pkg::NUM_DIGIT;
			end else if (!(num_q == mcp_pkg::NUM_SKIP && c_space)) begin
				num_n = mcp_pkg::NUM_STOP;
			end
		end
	end

	// Next state of the line parser and the push toward the queue.
	always_comb begin
		phase_d  = phase_q;
		alive_d  = alive_q;
		pos_d    = pos_q;
		trail_d  = trail_q;
		num_d    = num_q;
		ffne_d   = ffne_q;
		lneg_d   = lneg_q;
		lmag_d   = lmag_q;
		rneg_d   = rneg_q;
		rmag_d   = rmag_q;
		push     = 1'b0;
		push_cmd = kw_cmd;
		if (accept) begin
			if (rx_byte == mcp_pkg::CH_NEWLINE) begin
				if (phase_q == mcp_pkg::PH_BODY) begin
					push = kw_found;
				end else if (phase_q == mcp_pkg::PH_FIELD2) begin
					push     = 1'b1;
					push_cmd = mcp_pkg::CMD_MOTOR;
				end
				phase_d = mcp_pkg::PH_LEAD;
				alive_d = mcp_pkg::KW_ALL;
				pos_d   = 3'd0;
				trail_d = 1'b0;
				num_d   = mcp_pkg::NUM_SKIP;
				ffne_d  = 1'b0;
				lneg_d  = 1'b0;
				lmag_d  = '0;
				rneg_d  = 1'b0;
				rmag_d  = '0;
			end else begin
				case (phase_q)
					mcp_pkg::PH_LEAD, mcp_pkg::PH_BODY: begin
						if (phase_q == mcp_pkg::PH_BODY || !c_space) begin
							phase_d = mcp_pkg::PH_BODY;
							if (c_space) begin
								trail_d = 1'b1;
							end else if (trail_q) begin
								phase_d = mcp_pkg::PH_DEAD;
							end else begin
								alive_d = alive_body;
								pos_d   = pos_inc;
								if (alive_body[mcp_pkg::KW_PREFIX] && pos_inc == 3'd2) begin
									phase_d = mcp_pkg::PH_FIELD1;
									num_d   = mcp_pkg::NUM_SKIP;
								end else if (alive_body == '0) begin
									phase_d = mcp_pkg::PH_DEAD;
								end
							end
						end
					end
					mcp_pkg::PH_FIELD1: begin
						if (rx_byte == mcp_pkg::CH_COMMA) begin
							if (ffne_q) begin
								phase_d = mcp_pkg::PH_FIELD2;
								num_d   = mcp_pkg::NUM_SKIP;
							end else begin
								phase_d = mcp_pkg::PH_DEAD;
							end
						end else begin
							ffne_d = 1'b1;
							num_d  = num_n;
							lneg_d = fld_neg_n;
							lmag_d = fld_mag_n;
						end
					end
					mcp_pkg::PH_FIELD2: begin
						num_d  = num_n;
						rneg_d = fld_neg_n;
						rmag_d = fld_mag_n;
					end
					default: begin
					end
				endcase
			end
		end
	end

	assign push_entry = {push_cmd, lneg_q, lmag_q, rneg_q, rmag_q};

	// Parser state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= mcp_pkg::PH_LEAD;
			alive_q <= mcp_pkg::KW_ALL;
			pos_q   <= 3'd0;
			trail_q <= 1'b0;
			num_q   <= mcp_pkg::NUM_SKIP;
			ffne_q  <= 1'b0;
			lneg_q  <= 1'b0;
			lmag_q  <= '0;
			rneg_q  <= 1'b0;
			rmag_q  <= '0;
		end else begin
			phase_q <= phase_d;
			alive_q <= alive_d;
			pos_q   <= pos_d;
			trail_q <= trail_d;
			num_q   <= num_d;
			ffne_q  <= ffne_d;
			lneg_q  <= lneg_d;
			lmag_q  <= lmag_d;
			rneg_q  <= rneg_d;
			rmag_q  <= rmag_d;
		end
	end

endmodule

`default_nettype wire

// ===== sv/mcp_queue.sv =====
// Short command queue between the parser front end and the output back end.
// Depends on mcp_pkg for its depth and status struct.
`default_nettype none

module mcp_queue #(
	parameter int unsigned ENTRY_W = 21
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   push,
	input  wire logic [ENTRY_W-1:0]     push_entry,
	input  wire logic                   pop,
	output logic [ENTRY_W-1:0]          head_entry,
	output mcp_pkg::queue_status_t      status
);

	logic [ENTRY_W-1:0]           mem_q [mcp_pkg::QUEUE_DEPTH];
	logic [mcp_pkg::QUEUE_AW-1:0] wr_ptr_q;
	logic [mcp_pkg::QUEUE_AW-1:0] rd_ptr_q;
	logic [mcp_pkg::QUEUE_AW:0]   count_q;

	assign status.full  = (count_q == (mcp_pkg::QUEUE_AW + 1)'(mcp_pkg::QUEUE_DEPTH));
	assign status.empty = (count_q == '0);
	assign head_entry   = mem_q[rd_ptr_q];

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// ===== sv/mcp_back.sv =====
// Back end: turns a queued command into motor directions and duties and holds
// the result in the output register. Depends on mcp_pkg.
`default_nettype none

module mcp_back #(
	parameter int unsigned DUTY_MAX = 255,
	parameter int unsigned MAG_W    = 8,
	parameter int unsigned ENTRY_W  = 5 + 2 * MAG_W
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic [7:0]             straight_speed,
	input  wire logic [7:0]             turn_speed,
	input  wire logic [ENTRY_W-1:0]     head_entry,
	input  wire logic                   q_empty,
	output logic                        pop,
	output logic                        out_valid,
	input  wire logic                   out_stall,
	output logic                        left_reverse,
	output logic [7:0]                  left_duty,
	output logic                        right_reverse,
	output logic [7:0]                  right_duty
);

	mcp_pkg::cmd_t    cmd;
	logic             lneg;
	logic [MAG_W-1:0] lmag;
	logic             rneg;
	logic [MAG_W-1:0] rmag;
	logic [7:0]       s_clamp;
	logic [7:0]       t_clamp;
	logic             l_rev_d, r_rev_d;
	logic [7:0]       l_duty_d, r_duty_d;
	logic             valid_q;

	assign {cmd, lneg, lmag, rneg, rmag} = head_entry;

	// Keyword speeds never exceed the duty limit.
	assign s_clamp = (17'(straight_speed) > 17'(DUTY_MAX)) ? 8'(DUTY_MAX) : straight_speed;
	assign t_clamp = (17'(turn_speed) > 17'(DUTY_MAX)) ? 8'(DUTY_MAX) : turn_speed;

	// Motor commands for each command code; zero duty always reads as forward.
	always_comb begin
		case (cmd)
			mcp_pkg::CMD_FWD: begin
				l_rev_d = 1'b0; l_duty_d = s_clamp;
				r_rev_d = 1'b0; r_duty_d = s_clamp;
			end
			mcp_pkg::CMD_BWD: begin
				l_rev_d = (s_clamp != 8'd0); l_duty_d = s_clamp;
				r_rev_d = (s_clamp != 8'd0); r_duty_d = s_clamp;
			end
			mcp_pkg::CMD_LEFT: begin
				l_rev_d = (t_clamp != 8'd0); l_duty_d = t_clamp;
				r_rev_d = 1'b0;              r_duty_d = t_clamp;
			end
			mcp_pkg::CMD_RIGHT: begin
				l_rev_d = 1'b0;              l_duty_d = t_clamp;
				r_rev_d = (t_clamp != 8'd0); r_duty_d = t_clamp;
			end
			mcp_pkg::CMD_MOTOR: begin
				l_rev_d = lneg && (lmag != '0); l_duty_d = 8'(lmag);
				r_rev_d = rneg && (rmag != '0); r_duty_d = 8'(rmag);
			end
			default: begin
				l_rev_d = 1'b0; l_duty_d = 8'd0;
				r_rev_d = 1'b0; r_duty_d = 8'd0;
			end
		endcase
	end

	assign pop       = !q_empty && (!valid_q || !out_stall);
	assign out_valid = valid_q;

	// Output valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (!valid_q || !out_stall) begin
			valid_q <= !q_empty;
		end
	end

	// Output payload register, loaded on every transfer out of the queue.
	always_ff @(posedge clk) begin
		if (pop) begin
			left_reverse  <= l_rev_d;
			left_duty     <= l_duty_d;
			right_reverse <= r_rev_d;
			right_duty    <= r_duty_d;
		end
	end

endmodule

`default_nettype wire

// ===== sv/motor_command_parser.sv =====
// Motor command parser top level: configuration registers, parser front end,
// command queue and output back end. Depends on mcp_pkg and the mcp_* modules.
// Throughput: one byte per cycle while not stalled; a result goes through the queue and the output register.
// The input stalls only while the four-entry queue is full behind a stalled output.
// Reset clears the parser state, queue and output valid; speeds return to 200 and 150.
`default_nettype none

module motor_command_parser #(
	parameter int unsigned DUTY_MAX = 255
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_wr_en,
	input  wire logic [mcp_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [7:0]                    cfg_data,
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic [7:0]                    rx_byte,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic                               left_reverse,
	output logic [7:0]                         left_duty,
	output logic                               right_reverse,
	output logic [7:0]                         right_duty
);

	localparam int unsigned MAG_W   = $clog2(DUTY_MAX + 1);
	localparam int unsigned ENTRY_W = 5 + 2 * MAG_W;

	logic [7:0]             straight_q;
	logic [7:0]             turn_q;
	logic                   push;
	logic [ENTRY_W-1:0]     push_entry;
	logic                   pop;
	logic [ENTRY_W-1:0]     head_entry;
	mcp_pkg::queue_status_t q_status;

	assign in_stall = q_status.full;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			straight_q <= mcp_pkg::STRAIGHT_RESET;
			turn_q     <= mcp_pkg::TURN_RESET;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				mcp_pkg::REG_STRAIGHT: straight_q <= cfg_data;
				mcp_pkg::REG_TURN:     turn_q     <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	mcp_front #(
		.DUTY_MAX (DUTY_MAX),
		.MAG_W    (MAG_W),
		.ENTRY_W  (ENTRY_W)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.rx_byte    (rx_byte),
		.q_full     (q_status.full),
		.push       (push),
		.push_entry (push_entry)
	);

	mcp_queue #(
		.ENTRY_W (ENTRY_W)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.head_entry (head_entry),
		.status     (q_status)
	);

	mcp_back #(
		.DUTY_MAX (DUTY_MAX),
		.MAG_W    (MAG_W),
		.ENTRY_W  (ENTRY_W)
	) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.straight_speed (straight_q),
		.turn_speed     (turn_q),
		.head_entry     (head_entry),
		.q_empty        (q_status.empty),
		.pop            (pop),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.left_reverse   (left_reverse),
		.left_duty      (left_duty),
		.right_reverse  (right_reverse),
		.right_duty     (right_duty)
	);

	// The front end never writes into a full queue.
	assert property (@(posedge clk) disable iff (!arst_n) push |-> !q_status.full)
		else $error("command pushed into a full queue");

	// The back end never reads an empty queue.
	assert property (@(posedge clk) disable iff (!arst_n) pop |-> !q_status.empty)
		else $error("command popped from an empty queue");

	// A waiting command reaches an empty output register in the next cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		(!q_status.empty && !out_valid) |=> out_valid)
		else $error("queued command did not reach the output register");

endmodule

`default_nettype wire

// ===== tb/sv/motor_command_parser_tb.sv =====
// Self-checking testbench for motor_command_parser: streams text lines through the byte
// channel and compares each motor command with a line-parser predictor kept in this module.
// Depends on mcp_pkg and the motor_command_parser RTL.
module motor_command_parser_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned DUTY_LIMIT = 255;

	// One motor command as the output channel carries it.
	typedef struct packed {
		logic       left_rev;
		logic [7:0] left_duty;
		logic       right_rev;
		logic [7:0] right_duty;
	} motor_cmd_t;

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          cfg_wr_en = 1'b0;
	logic [mcp_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [7:0]                    cfg_data = '0;
	logic                          in_valid = 1'b0;
	logic                          in_stall;
	logic [7:0]                    rx_byte = '0;
	logic                          out_valid;
	logic                          out_stall = 1'b0;
	logic                          left_reverse;
	logic [7:0]                    left_duty;
	logic                          right_reverse;
	logic [7:0]                    right_duty;

	motor_command_parser #(
		.DUTY_MAX(DUTY_LIMIT)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.rx_byte(rx_byte),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.left_reverse(left_reverse),
		.left_duty(left_duty),
		.right_reverse(right_reverse),
		.right_duty(right_duty)
	);

	// Predictor copy of the speed registers and the line parser state.
	logic [7:0]            straight_spd = 8'd200;
	logic [7:0]            turn_spd = 8'd150;
	mcp_pkg::phase_t       line_ph;
	logic [5:0]            word_alive;
	int unsigned           word_pos;
	bit                    blank_after_word;
	mcp_pkg::num_phase_t   num_ph;
	bit                    first_nonempty;
	bit                    lft_neg;
	int unsigned           lft_mag;
	bit                    rgt_neg;
	int unsigned           rgt_mag;

	motor_cmd_t   pending_cmds [$];
	logic [7:0]   line_buf [$];

	int unsigned  error_count = 0;
	int unsigned  bytes_sent = 0;
	int unsigned  results_seen = 0;
	int unsigned  stall_left = 0;
	bit           send_gaps_on = 1'b1;
	bit           recv_stalls_on = 1'b1;
	bit           hold_stall = 1'b0;

	// Clock.
	initial begin
		forever #5 clk = ~clk;
	end

	// Watchdog for a hung handshake.
	initial begin
		#(5_000_000);
		$display("DONE: errors detected");
		$finish;
	end

	task automatic report_error(input string msg);
		$display("ERROR at %0t: %s", $time, msg);
		error_count++;
	endtask

	function automatic bit is_blank(input logic [7:0] c);
		return (c == mcp_pkg::CH_SPACE) || (c >= mcp_pkg::CH_TAB && c <= mcp_pkg::CH_CR);
	endfunction

	function automatic string kw_text(input mcp_pkg::cmd_t k);
		case (k)
			mcp_pkg::CMD_FWD:   return "FWD";
			mcp_pkg::CMD_BWD:   return "BWD";
			mcp_pkg::CMD_LEFT:  return "LEFT";
			mcp_pkg::CMD_RIGHT: return "RIGHT";
			mcp_pkg::CMD_STOP:  return "STOP";
			default:            return "M:";
		endcase
	endfunction

	function automatic int unsigned clamp_duty(input int unsigned v);
		return (v > DUTY_LIMIT) ? DUTY_LIMIT : v;
	endfunction

	// Direction is only reported for a nonzero duty.
	function automatic motor_cmd_t make_cmd(input bit lrev, input int unsigned lmag,
			input bit rrev, input int unsigned rmag);
		motor_cmd_t m;
		m.left_rev   = lrev && (lmag != 0);
		m.left_duty  = 8'(lmag);
		m.right_rev  = rrev && (rmag != 0);
		m.right_duty = 8'(rmag);
		return m;
	endfunction

	task automatic clear_line_state();
		line_ph          = mcp_pkg::PH_LEAD;
		word_alive       = '1;
		word_pos         = 0;
		blank_after_word = 1'b0;
		num_ph           = mcp_pkg::NUM_SKIP;
		first_nonempty   = 1'b0;
		lft_neg          = 1'b0;
		lft_mag          = 0;
		rgt_neg          = 1'b0;
		rgt_mag          = 0;
	endtask

	// Signed decimal reader: blanks, one sign, digits, then stop at anything else.
	task automatic feed_digits(input logic [7:0] c, inout bit neg, inout int unsigned mag);
		if (num_ph != mcp_pkg::NUM_STOP) begin
			if (c >= mcp_pkg::CH_ZERO && c <= mcp_pkg::CH_NINE) begin
				mag = clamp_duty(mag * 10 + (c - mcp_pkg::CH_ZERO));
				num_ph = mcp_pkg::NUM_DIGIT;
			end else if (num_ph == mcp_pkg::NUM_SKIP &&
				(c == mcp_pkg::CH_PLUS || c == mcp_pkg::CH_MINUS)) begin
				neg = (c == mcp_pkg::CH_MINUS);
				num_ph = mcp_pkg::NUM_DIGIT;
			end else if (!(num_ph == mcp_pkg::NUM_SKIP && is_blank(c))) begin
				num_ph = mcp_pkg::NUM_STOP;
			end
		end
	endtask

	// Keyword matcher: narrows the candidate set one character at a time.
	task automatic feed_word_char(input logic [7:0] c);
		string         w;
		mcp_pkg::cmd_t kc;
		if (is_blank(c)) begin
			blank_after_word = 1'b1;
		end else if (blank_after_word) begin
			line_ph = mcp_pkg::PH_DEAD;
		end else begin
			for (int k = 0; k < 6; k++) begin
				kc = mcp_pkg::cmd_t'(k);
				w = kw_text(kc);
				if (word_alive[k]) begin
					if (!(word_pos < w.len() && w[word_pos] == c))
						word_alive[k] = 1'b0;
				end
			end
			if (word_pos < 7)
				word_pos++;
			if (word_alive[mcp_pkg::CMD_MOTOR] && word_pos == 2) begin
				line_ph = mcp_pkg::PH_FIELD1;
				num_ph = mcp_pkg::NUM_SKIP;
			end else if (word_alive == '0) begin
				line_ph = mcp_pkg::PH_DEAD;
			end
		end
	endtask

	// End of line: queue the command that the line stands for, if any.
	task automatic close_line();
		string         w;
		mcp_pkg::cmd_t kc;
		bit            found;
		int unsigned   s;
		int unsigned   t;
		found = 1'b0;
		kc = mcp_pkg::CMD_FWD;
		s = clamp_duty(straight_spd);
		t = clamp_duty(turn_spd);
		if (line_ph == mcp_pkg::PH_BODY) begin
			for (int k = 0; k < 5; k++) begin
				w = kw_text(mcp_pkg::cmd_t'(k));
				if (!found && word_alive[k] && word_pos == w.len()) begin
					found = 1'b1;
					kc = mcp_pkg::cmd_t'(k);
				end
			end
			if (found) begin
				case (kc)
					mcp_pkg::CMD_FWD:
						pending_cmds.push_back(make_cmd(1'b0, s, 1'b0, s));
					mcp_pkg::CMD_BWD:
						pending_cmds.push_back(make_cmd(1'b1, s, 1'b1, s));
					mcp_pkg::CMD_LEFT:
						pending_cmds.push_back(make_cmd(1'b1, t, 1'b0, t));
					mcp_pkg::CMD_RIGHT:
						pending_cmds.push_back(make_cmd(1'b0, t, 1'b1, t));
					default:
						pending_cmds.push_back(make_cmd(1'b0, 0, 1'b0, 0));
				endcase
			end
		end else if (line_ph == mcp_pkg::PH_FIELD2) begin
			pending_cmds.push_back(make_cmd(lft_neg, lft_mag, rgt_neg, rgt_mag));
		end
		clear_line_state();
	endtask

	// Advance the predictor by one transferred byte.
	task automatic parse_rx_byte(input logic [7:0] c);
		if (c == mcp_pkg::CH_NEWLINE) begin
			close_line();
		end else begin
			case (line_ph)
				mcp_pkg::PH_LEAD: begin
					if (!is_blank(c)) begin
						line_ph = mcp_pkg::PH_BODY;
						feed_word_char(c);
					end
				end
				mcp_pkg::PH_BODY: feed_word_char(c);
				mcp_pkg::PH_FIELD1: begin
					if (c == mcp_pkg::CH_COMMA) begin
						if (first_nonempty) begin
							line_ph = mcp_pkg::PH_FIELD2;
							num_ph = mcp_pkg::NUM_SKIP;
						end else begin
							line_ph = mcp_pkg::PH_DEAD;
						end
					end else begin
						first_nonempty = 1'b1;
						feed_digits(c, lft_neg, lft_mag);
					end
				end
				mcp_pkg::PH_FIELD2: feed_digits(c, rgt_neg, rgt_mag);
				default: ;
			endcase
		end
	endtask

	// Present one byte, hold it until the transfer, then update the predictor.
	task automatic send_byte(input logic [7:0] c);
		int unsigned gap;
		gap = send_gaps_on ? $urandom_range(0, 4) : 0;
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		rx_byte  <= c;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		parse_rx_byte(c);
		bytes_sent++;
	endtask

	task automatic add_text(input string s);
		for (int i = 0; i < s.len(); i++)
			line_buf.push_back(s[i]);
	endtask

	task automatic send_line_buf();
		foreach (line_buf[i])
			send_byte(line_buf[i]);
		send_byte(mcp_pkg::CH_NEWLINE);
		line_buf.delete();
	endtask

	task automatic send_text(input string s);
		add_text(s);
		send_line_buf();
	endtask

	// Drop valid and wait until every expected command has been transferred.
	task automatic wait_idle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_cmds.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(input logic [mcp_pkg::CFG_IDX_W-1:0] idx,
			input logic [7:0] val);
		wait_idle();
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		if (idx == mcp_pkg::REG_STRAIGHT)
			straight_spd = val;
		else if (idx == mcp_pkg::REG_TURN)
			turn_spd = val;
	endtask

	// Receiver stall: forced by hold_stall, else a fresh random one per result if enabled.
	always @(negedge clk) begin
		if (hold_stall) begin
			out_stall <= 1'b1;
		end else if (stall_left > 0) begin
			out_stall <= 1'b1;
			stall_left--;
		end else begin
			out_stall <= 1'b0;
		end
	end

	// Compare each transferred command with the oldest expectation.
	always @(posedge clk) begin : check_results
		motor_cmd_t want;
		if (arst_n && out_valid && !out_stall) begin
			results_seen++;
			stall_left = recv_stalls_on ? $urandom_range(0, 4) : 0;
			if (pending_cmds.size() == 0) begin
				report_error("motor command transferred with none expected");
			end else begin
				want = pending_cmds.pop_front();
				if (left_reverse !== want.left_rev)
					report_error($sformatf("left_reverse got %0b want %0b",
						left_reverse, want.left_rev));
				if (left_duty !== want.left_duty)
					report_error($sformatf("left_duty got %0d want %0d",
						left_duty, want.left_duty));
				if (right_reverse !== want.right_rev)
					report_error($sformatf("right_reverse got %0b want %0b",
						right_reverse, want.right_rev));
				if (right_duty !== want.right_duty)
					report_error($sformatf("right_duty got %0d want %0d",
						right_duty, want.right_duty));
			end
		end
	end

	// Random text pieces.
	function automatic logic [7:0] random_blank();
		case ($urandom_range(0, 7))
			0: return mcp_pkg::CH_TAB;
			1: return mcp_pkg::CH_CR;
			2: return 8'd11;
			3: return 8'd12;
			default: return mcp_pkg::CH_SPACE;
		endcase
	endfunction

	task automatic add_blanks(input int unsigned max_count);
		repeat ($urandom_range(0, max_count))
			line_buf.push_back(random_blank());
	endtask

	task automatic add_number();
		int unsigned ndig;
		if ($urandom_range(0, 3) == 0)
			add_blanks(2);
		case ($urandom_range(0, 3))
			0: line_buf.push_back(mcp_pkg::CH_MINUS);
			1: line_buf.push_back(mcp_pkg::CH_PLUS);
			default: ;
		endcase
		ndig = ($urandom_range(0, 9) == 0) ? $urandom_range(4, 7) : $urandom_range(0, 3);
		repeat (ndig)
			line_buf.push_back(mcp_pkg::CH_ZERO + 8'($urandom_range(0, 9)));
		if ($urandom_range(0, 5) == 0)
			line_buf.push_back(8'($urandom_range(0, 255)));
	endtask

	task automatic add_random_line();
		int unsigned kind;
		int unsigned start;
		kind = $urandom_range(0, 99);
		add_blanks(2);
		if (kind < 45) begin
			// Motor line with random numbers; the comma is sometimes missing or trailing text is added.
			add_text("M:");
			add_number();
			if ($urandom_range(0, 9) != 0) begin
				line_buf.push_back(mcp_pkg::CH_COMMA);
				add_number();
			end
			if ($urandom_range(0, 4) == 0)
				add_text(",9x");
			add_blanks(2);
		end else if (kind < 75) begin
			// Keyword, sometimes damaged.
			start = line_buf.size();
			add_text(kw_text(mcp_pkg::cmd_t'($urandom_range(0, 4))));
			case ($urandom_range(0, 9))
				0: line_buf[start + $urandom_range(0, 2)] = 8'($urandom_range(0, 255));
				1: void'(line_buf.pop_back());
				2: line_buf.push_back(8'($urandom_range(0, 255)));
				3: add_text(" D");
				default: ;
			endcase
			add_blanks(3);
		end else if (kind < 90) begin
			// Arbitrary bytes.
			repeat ($urandom_range(1, 8))
				line_buf.push_back(8'($urandom_range(0, 255)));
		end else begin
			// Broken motor prefixes and fields.
			case ($urandom_range(0, 3))
				0: add_text("M");
				1: add_text("M:");
				2: add_text("M:,");
				default: add_text("M;");
			endcase
			add_number();
		end
		send_line_buf();
	endtask

	// Tests.
	task automatic test_keywords();
		send_text("FWD");
		send_text("BWD");
		send_text("LEFT");
		send_text("RIGHT");
		send_text("STOP");
		// Surrounding whitespace is trimmed; inner whitespace kills the line.
		send_text(" \tRIGHT \r");
		send_text("F WD");
		send_text("STOP X");
		send_text("FWDX");
		send_text("FW");
		send_text("");
		line_buf.push_back(8'hC8);
		add_text("FWD");
		send_line_buf();
		wait_idle();
	endtask

	task automatic test_motor_lines();
		send_text("M:255,-255");
		send_text("M:-0,+0");
		send_text("M:99999,-123456");
		send_text("M:,5");
		send_text("M: ,7");
		send_text("M:5,");
		send_text("M:12");
		send_text("M:3x,4,5");
		send_text("M:- 5,3");
		send_text("M:+-3,-2");
		send_text("  M: 17 , \t42 ");
		// A zero byte is an ordinary character in the first field.
		add_text("M:");
		line_buf.push_back(8'h00);
		add_text(",1");
		send_line_buf();
		wait_idle();
	endtask

	task automatic test_speed_registers();
		write_reg(mcp_pkg::REG_STRAIGHT, 8'd0);
		write_reg(mcp_pkg::REG_TURN, 8'd0);
		send_text("BWD");
		send_text("LEFT");
		send_text("RIGHT");
		send_text("FWD");
		write_reg(mcp_pkg::REG_STRAIGHT, 8'd255);
		write_reg(mcp_pkg::REG_TURN, 8'd255);
		send_text("BWD");
		send_text("LEFT");
		send_text("RIGHT");
		write_reg(mcp_pkg::REG_STRAIGHT, 8'd1);
		write_reg(mcp_pkg::REG_TURN, 8'd254);
		send_text("FWD");
		send_text("LEFT");
		wait_idle();
	endtask

	// Hold the output stalled long enough that the queue fills and the input stalls.
	task automatic test_back_pressure();
		send_gaps_on = 1'b0;
		hold_stall = 1'b1;
		fork
			begin
				repeat (60) @(posedge clk);
				hold_stall = 1'b0;
			end
		join_none
		repeat (10)
			send_text("FWD");
		wait_idle();
		send_gaps_on = 1'b1;
	endtask

	task automatic test_random_traffic();
		int unsigned target;
		for (int phase = 0; phase < 4; phase++) begin
			send_gaps_on   = (phase != 2);
			recv_stalls_on = (phase != 2);
			write_reg(mcp_pkg::REG_STRAIGHT, 8'($urandom_range(0, 255)));
			write_reg(mcp_pkg::REG_TURN, 8'($urandom_range(0, 255)));
			target = bytes_sent + 75;
			while (bytes_sent < target)
				add_random_line();
		end
		wait_idle();
	endtask

	// Main sequence.
	initial begin
		clear_line_state();
		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		test_keywords();
		test_motor_lines();
		test_speed_registers();
		test_back_pressure();
		test_random_traffic();
		wait_idle();
		repeat (20) @(posedge clk);
		if (error_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
